>>> sv/ptfs_pkg.sv
// Shared types, sizes and control structs for the periodic task fire scheduler.
`default_nettype none
package ptfs_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int MASK_W    = 16;
   localparam int MASK_N    = (MAX_TASKS < MASK_W) ? MAX_TASKS : MASK_W;
   localparam int MS_W      = 16;
   localparam int DVD_W     = MS_W + 1;
   localparam int BIT_W     = $clog2(DVD_W + 1);
   localparam int ENTRY_W   = 2 * MS_W;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_ROUND = 1'b1;

   typedef struct packed {
      logic            kind;
      logic            start_now;
      logic [MS_W-1:0] phase_ms;
      logic [MS_W-1:0] period_ms;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] fire_mask;
      logic [MS_W-1:0]   wait_ms;
      logic              table_full;
   } rsp_type;

   typedef struct packed {
      logic add_exec;
      logic round_start;
      logic load_task;
      logic div_step;
      logic upd_task;
      logic time_upd;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic div_last;
      logic last_task;
   } dp_status_type;

endpackage
`default_nettype wire

>>> sv/periodic_task_fire_scheduler.sv
// Add request: result loads once the output is free; next request taken the cycle after.
// Round request: per stored task a table read, load, 17-step shared remainder unit
// and compare, then a time update and finish; the remainder unit is bit-serial.
// One request is in work at a time; a finished result waits in the output register.
// Synchronous reset empties the task table, clears pending flags, time and largest period.
`default_nettype none
module periodic_task_fire_scheduler
   import ptfs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ptfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   ptfs_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

>>> sv/ptfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptfs_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/ptfs_ctrl.sv
// Controller state machine: sequences add requests and scheduling rounds.
`default_nettype none
module ptfs_ctrl
   import ptfs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_kind,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output logic               req_stall,
   output logic               rsp_valid,
   output ctrl_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_LD   = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;
   localparam logic [2:0] S_TIME = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_kind == KIND_ADD) begin
                  cmd.add_exec = 1'b1;
                  state_in     = S_FIN;
               end else begin
                  cmd.round_start = 1'b1;
                  state_in        = status.count_zero ? S_TIME : S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_LD;
         end
         S_LD: begin
            cmd.load_task = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.upd_task = 1'b1;
            state_in     = status.last_task ? S_TIME : S_RD;
         end
         S_TIME: begin
            cmd.time_upd = 1'b1;
            state_in     = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("response raised outside the finish state");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

endmodule
`default_nettype wire

>>> sv/ptfs_dp.sv
// Datapath: task table, pending flags, shared remainder unit and response register.
`default_nettype none
module ptfs_dp
   import ptfs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_type      req_data,
   input  wire ctrl_cmd_type cmd,
   output dp_status_type     status,
   output rsp_type           rsp_data
);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [MS_W-1:0]      largest_ff, largest_in;
   logic [MS_W-1:0]      time_ff, time_in;
   logic [MAX_TASKS-1:0] pending_ff, pending_in;
   logic [MAX_TASKS-1:0] newpend_ff, newpend_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [MS_W-1:0]      per_ff, per_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [MS_W-1:0]      rem_ff, rem_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [MS_W-1:0]      wait_ff, wait_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic                 full_ff, full_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 ram_we;
   logic [ENTRY_W-1:0]   ram_rd;
   logic [IDX_W-1:0]     count_idx;
   logic                 table_full_w;
   logic [MS_W-1:0]      per_store;
   logic [MASK_W-1:0]    fire_bits;
   logic [DVD_W-1:0]     trial;
   logic [DVD_W-1:0]     trial_diff;
   logic [MS_W-1:0]      task_delay;
   logic [DVD_W-1:0]     time_sum;
   logic [DVD_W-1:0]     time_wrap;

   assign count_idx    = count_ff[IDX_W-1:0];
   assign table_full_w = (count_ff == CNT_W'(MAX_TASKS));
   assign per_store    = (req_data.period_ms == '0) ? MS_W'(1) : req_data.period_ms;

   always_comb begin
      fire_bits = '0;
      for (int i = 0; i < MASK_N; i++) begin
         fire_bits[i] = pending_ff[i];
      end
   end

   // one restoring step of (time + phase) mod period
   assign trial      = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_diff = trial - {1'b0, per_ff};
   assign task_delay = per_ff - rem_ff;

   assign time_sum  = {1'b0, time_ff} + {1'b0, wait_ff};
   assign time_wrap = (time_sum >= {1'b0, largest_ff}) ? time_sum - {1'b0, largest_ff}
                                                        : time_sum;

   ptfs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_idx),
      .wr_data ({req_data.phase_ms, per_store}),
      .rd_addr (idx_ff),
      .rd_data (ram_rd)
   );

   always_comb begin
      count_in   = count_ff;
      largest_in = largest_ff;
      time_in    = time_ff;
      pending_in = pending_ff;
      newpend_in = newpend_ff;
      idx_in     = idx_ff;
      per_in     = per_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      bit_in     = bit_ff;
      wait_in    = wait_ff;
      mask_in    = mask_ff;
      full_in    = full_ff;
      rsp_in     = rsp_ff;
      ram_we     = 1'b0;

      if (cmd.add_exec) begin
         mask_in = '0;
         wait_in = '0;
         full_in = table_full_w;
         if (!table_full_w) begin
            ram_we                = 1'b1;
            pending_in[count_idx] = req_data.start_now;
            if (per_store > largest_ff) begin
               largest_in = per_store;
            end
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.round_start) begin
         mask_in    = fire_bits;
         wait_in    = largest_ff;
         newpend_in = '0;
         idx_in     = '0;
         full_in    = 1'b0;
      end

      if (cmd.load_task) begin
         per_in = ram_rd[MS_W-1:0];
         dvd_in = {1'b0, time_ff} + {1'b0, ram_rd[ENTRY_W-1:MS_W]};
         rem_in = '0;
         bit_in = BIT_W'(DVD_W);
      end

      if (cmd.div_step) begin
         if (trial >= {1'b0, per_ff}) begin
            rem_in = trial_diff[MS_W-1:0];
         end else begin
            rem_in = trial[MS_W-1:0];
         end
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         bit_in = bit_ff - BIT_W'(1);
      end

      if (cmd.upd_task) begin
         if (task_delay == wait_ff) begin
            newpend_in[idx_ff] = 1'b1;
         end else if (task_delay < wait_ff) begin
            // new minimum: only this task stays marked
            wait_in            = task_delay;
            newpend_in         = '0;
            newpend_in[idx_ff] = 1'b1;
         end
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.time_upd) begin
         pending_in = newpend_ff;
         if (largest_ff != '0) begin
            time_in = time_wrap[MS_W-1:0];
         end
      end

      if (cmd.out_load) begin
         rsp_in.fire_mask  = mask_ff;
         rsp_in.wait_ms    = wait_ff;
         rsp_in.table_full = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         largest_ff <= '0;
         time_ff    <= '0;
         pending_ff <= '0;
      end else begin
         count_ff   <= count_in;
         largest_ff <= largest_in;
         time_ff    <= time_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      newpend_ff <= newpend_in;
      idx_ff     <= idx_in;
      per_ff     <= per_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      bit_ff     <= bit_in;
      wait_ff    <= wait_in;
      mask_ff    <= mask_in;
      full_ff    <= full_in;
      rsp_ff     <= rsp_in;
   end

   assign status.count_zero = (count_ff == '0);
   assign status.div_last   = (bit_ff == BIT_W'(1));
   assign status.last_task  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign rsp_data          = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TASKS))
      else $error("task count beyond table size");

   a_time_bound: assert property (@(posedge clock) disable iff (reset)
      largest_ff != '0 |-> time_ff < largest_ff)
      else $error("current time not below largest period");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_task |-> rem_ff < per_ff)
      else $error("remainder not below period");

   a_pending_live: assert property (@(posedge clock) disable iff (reset)
      (pending_ff >> count_ff) == '0)
      else $error("pending flag set on an empty slot");

endmodule
`default_nettype wire

>>> tb/tb_periodic_task_fire_scheduler.sv
// Self-checking testbench for the periodic task fire scheduler: directed, pressure and random requests.
`timescale 1ns / 1ps
module tb_periodic_task_fire_scheduler;
   import ptfs_pkg::*;

   localparam int QUIET_LIMIT  = 6000;
   localparam int HOLD_CYCLES  = 700;
   localparam int DRAIN_CYCLES = 400;
   localparam int ROUND_PCT    = 70;
   localparam int MAX_REPORTS  = 100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int error_count  = 0;
   int quiet_cycles = 0;
   int hold_left    = 0;
   bit hold_go      = 1'b0;
   bit hold_seen    = 1'b0;

   // Shadow copy of the task table, time and largest period
   int unsigned sched_count      = 0;
   int unsigned sched_top_period = 0;
   int unsigned sched_now        = 0;
   int unsigned sched_period [MAX_TASKS];
   int unsigned sched_phase  [MAX_TASKS];
   bit          sched_pending[MAX_TASKS];

   rsp_type expected_fires[$];

   periodic_task_fire_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic rsp_type schedule_step(req_type rq);
      rsp_type     res;
      int unsigned per;
      int unsigned delay;
      int unsigned min_delay;
      res = '0;
      if (rq.kind == KIND_ROUND) begin
         min_delay = sched_top_period;
         for (int i = 0; i < sched_count; i++) begin
            if (sched_pending[i]) begin
               if (i < MASK_W) res.fire_mask[i] = 1'b1;
               sched_pending[i] = 1'b0;
            end
            per   = sched_period[i];
            // sum at full width, no wrap before the modulo
            delay = per - ((sched_now + sched_phase[i]) % per);
            if (delay == min_delay) begin
               sched_pending[i] = 1'b1;
            end else if (delay < min_delay) begin
               min_delay = delay;
               for (int j = 0; j < i; j++) sched_pending[j] = 1'b0;
               sched_pending[i] = 1'b1;
            end
         end
         if (sched_top_period != 0) sched_now = (sched_now + min_delay) % sched_top_period;
         res.wait_ms = MS_W'(min_delay);
      end else if (sched_count >= MAX_TASKS) begin
         res.table_full = 1'b1;
      end else begin
         per = (rq.period_ms == '0) ? 1 : rq.period_ms;
         sched_pending[sched_count] = rq.start_now;
         sched_phase[sched_count]   = rq.phase_ms;
         sched_period[sched_count]  = per;
         if (per > sched_top_period) sched_top_period = per;
         sched_count++;
      end
      return res;
   endfunction

   function automatic req_type make_add(logic start, logic [MS_W-1:0] phase,
                                        logic [MS_W-1:0] period);
      req_type rq;
      rq.kind      = KIND_ADD;
      rq.start_now = start;
      rq.phase_ms  = phase;
      rq.period_ms = period;
      return rq;
   endfunction

   // Round requests carry random junk in the unused fields
   function automatic req_type random_request(int round_pct);
      req_type rq;
      rq.kind      = ($urandom_range(99) < round_pct) ? KIND_ROUND : KIND_ADD;
      rq.start_now = 1'($urandom_range(1));
      rq.phase_ms  = MS_W'($urandom);
      rq.period_ms = MS_W'($urandom);
      return rq;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < MAX_REPORTS)
         $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_request(req_type rq);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      expected_fires.push_back(schedule_step(rq));
   endtask

   task automatic send_round();
      send_request(random_request(100));
   endtask

   task automatic test_empty_round();
      send_round();
   endtask

   task automatic test_table_fill();
      int unsigned periods[13] = '{2, 3, 4, 5, 6, 7, 8, 10, 12, 3, 6, 15, 4};
      logic [MS_W-1:0] phase;
      send_request(make_add(1'b1, '0, '0));
      send_round();
      send_request(make_add(1'b0, '1, '1));
      send_round();
      send_request(make_add(1'b1, MS_W'(3), MS_W'(7)));
      for (int i = 0; i < 13; i++) begin
         phase = (i % 4 == 0) ? '1 : MS_W'($urandom);
         send_request(make_add(i[0], phase, MS_W'(periods[i])));
      end
   endtask

   task automatic test_table_full();
      send_request(make_add(1'b1, '1, '1));
      repeat (3) send_round();
   endtask

   // Hold the result side off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      hold_go <= ~hold_go;
      repeat (24) send_request(random_request(20));
   endtask

   task automatic test_random_traffic(int count, int snd_pct, int rcv_pct);
      req_idle_pct <= snd_pct;
      rsp_idle_pct <= rcv_pct;
      repeat (count) send_request(random_request(ROUND_PCT));
   endtask

   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fires.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_data), '0);
         end else begin
            want = expected_fires.pop_front();
            if (rsp_data.fire_mask !== want.fire_mask)
               report_mismatch("fire_mask", 64'(rsp_data.fire_mask), 64'(want.fire_mask));
            if (rsp_data.wait_ms !== want.wait_ms)
               report_mismatch("wait_ms", 64'(rsp_data.wait_ms), 64'(want.wait_ms));
            if (rsp_data.table_full !== want.table_full)
               report_mismatch("table_full", 64'(rsp_data.table_full),
                               64'(want.table_full));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_periodic_task_fire_scheduler: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_round();
      test_table_fill();
      test_table_full();
      test_backpressure();
      test_random_traffic(486, 34, 82);
      test_random_traffic(486, 82, 34);
      test_random_traffic(486, 0, 0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_fires.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_periodic_task_fire_scheduler: clean");
      end else begin
         $display("tb_periodic_task_fire_scheduler: errors");
      end
      $finish;
   end

endmodule
